// ----- sv/fully_assoc_lru_tag_store_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the fully associative LRU tag store
// Each check is clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef FULLY_ASSOC_LRU_TAG_STORE_DEFINES_SVH
`define FULLY_ASSOC_LRU_TAG_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every edge
`define FALRU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define FALRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define FALRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FALRU_ASSERT(lbl, cond, msg)
`define FALRU_ASSERT_IMP(lbl, ante, cons, msg)
`define FALRU_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/falru_pkg.sv -----
// ---------------------------------------------------------------------------
// falru_pkg
// Shared constants and types for the fully associative LRU tag store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package falru_pkg;

  // Number of entries (2 to 16)
  localparam int LINES = 10;

  localparam int KEY_W  = 64;
  localparam int SIZE_W = 20;
  localparam int IDX_W  = 4;
  localparam int RANK_W = 4;

  // Rank held by the least recently used entry once every entry is valid
  localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(LINES - 1);

  // Request codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Search results rippled along the row of cells
  typedef struct packed {
    logic              hit_f;
    logic [IDX_W-1:0]  hit_idx;
    logic [SIZE_W-1:0] hit_size;
    logic [RANK_W-1:0] hit_rank;
    logic              free_f;
    logic [IDX_W-1:0]  free_idx;
    logic              lru_f;
    logic [IDX_W-1:0]  lru_idx;
  } chain_t;

  // Update command broadcast to every cell
  typedef struct packed {
    logic              apply;
    logic [IDX_W-1:0]  idx;
    logic              write;
    logic              age_all;
    logic [RANK_W-1:0] limit;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } upd_cmd_t;

  // Per-cell status seen by the top level
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
  } cell_stat_t;

endpackage

`default_nettype wire

// ----- sv/falru_if.sv -----
// ---------------------------------------------------------------------------
// falru_if
// Request and response channels of the tag store (valid/ready handshake).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface falru_req_if
  import falru_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KEY_W-1:0]  key;
  logic [SIZE_W-1:0] object_size;

  modport source (output valid, req_type, key, object_size, input ready);
  modport sink   (input valid, req_type, key, object_size, output ready);
endinterface

interface falru_rsp_if
  import falru_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [IDX_W-1:0]  line_index;
  logic [SIZE_W-1:0] stored_size;
  logic              evicted;

  modport source (output valid, hit, line_index, stored_size, evicted, input ready);
  modport sink   (input valid, hit, line_index, stored_size, evicted, output ready);
endinterface

`default_nettype wire

// ----- sv/fully_assoc_lru_tag_store.sv -----
// ---------------------------------------------------------------------------
// fully_assoc_lru_tag_store
// Fully associative tag store with exact LRU ranks, built as a row of cells.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (sink): req_type (0 lookup, 1 insert), 64-bit key and
//   20-bit object_size. rsp channel (source): hit, line_index, stored_size
//   and evicted, one response item per request item.
//   An accepted item is compared against every entry in the next cycle
//   (S_MATCH; the match results ripple down the row of cells, lowest index
//   first), and in the S_UPD state the ranks and the written entry are
//   updated and the response is loaded into the output register. req.ready
//   is high again in the update cycle, so the next item is taken while the last is updated.
//   The output register holds one response; while it is full and rsp.ready
//   is low the update waits, and req.ready stays low until it can finish.
//   A new request may be taken while a response still waits to be taken.
//   Reset (synchronous, rst high) clears every valid bit and rank and
//   empties the output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fully_assoc_lru_tag_store_defines.svh"

module fully_assoc_lru_tag_store
  import falru_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  falru_req_if.sink   req,
  falru_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_UPD   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Captured request
  logic              rq_type;
  logic [KEY_W-1:0]  rq_key;
  logic [SIZE_W-1:0] rq_size;

  // Resolved match, registered at the end of the compare cycle
  logic              sel_apply;
  logic [IDX_W-1:0]  sel_idx;
  logic              sel_write;
  logic              sel_age_all;
  logic [RANK_W-1:0] sel_limit;
  logic              sel_hit;
  logic [SIZE_W-1:0] sel_size;
  logic              sel_evict;

  // Response register
  logic              rsp_valid;
  logic              rsp_hit;
  logic [IDX_W-1:0]  rsp_idx;
  logic [SIZE_W-1:0] rsp_size;
  logic              rsp_evict;

  logic     accept;
  logic     upd_go;
  upd_cmd_t cmd;
  chain_t   chain [LINES+1];
  cell_stat_t stat [LINES];
  logic [LINES-1:0] valid_vec;
  logic [LINES-1:0] lru_vec;

  assign upd_go    = (state == S_UPD) && (!rsp_valid || rsp.ready);
  assign req.ready = (state == S_IDLE) || upd_go;
  assign accept    = req.valid && req.ready;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_MATCH;
      end
      S_MATCH: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (upd_go) state_next = accept ? S_MATCH : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      rq_type <= req.req_type;
      rq_key  <= req.key;
      rq_size <= req.object_size;
    end
  end

  // Row of cells
  assign chain[0] = chain_t'('0);

  always_comb begin
    cmd.apply   = upd_go && sel_apply;
    cmd.idx     = sel_idx;
    cmd.write   = sel_write;
    cmd.age_all = sel_age_all;
    cmd.limit   = sel_limit;
    cmd.key     = rq_key;
    cmd.size    = rq_size;
  end

  for (genvar g = 0; g < LINES; g++) begin : g_cell
    falru_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(g)),
      .cmp_key   (rq_key),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .stat      (stat[g])
    );
    assign valid_vec[g] = stat[g].valid;
    assign lru_vec[g]   = stat[g].valid && (stat[g].rank == LRU_RANK);
  end

  // Resolve the search at the end of the row
  always_ff @(posedge clk) begin
    if (state == S_MATCH) begin
      sel_hit     <= 1'b0;
      sel_size    <= '0;
      sel_evict   <= 1'b0;
      sel_age_all <= 1'b0;
      sel_limit   <= '0;
      sel_idx     <= '0;
      if (rq_type == REQ_LOOKUP) begin
        sel_apply <= chain[LINES].hit_f;
        sel_write <= 1'b0;
        if (chain[LINES].hit_f) begin
          sel_hit   <= 1'b1;
          sel_idx   <= chain[LINES].hit_idx;
          sel_size  <= chain[LINES].hit_size;
          sel_limit <= chain[LINES].hit_rank;
        end
      end else begin
        sel_apply <= 1'b1;
        sel_write <= 1'b1;
        if (chain[LINES].free_f) begin
          sel_idx     <= chain[LINES].free_idx;
          sel_age_all <= 1'b1;
        end else begin
          sel_idx   <= chain[LINES].lru_idx;
          sel_limit <= LRU_RANK;
          sel_evict <= 1'b1;
        end
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (upd_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      rsp_hit   <= sel_hit;
      rsp_idx   <= sel_idx;
      rsp_size  <= sel_size;
      rsp_evict <= sel_evict;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = rsp_hit;
  assign rsp.line_index  = rsp_idx;
  assign rsp.stored_size = rsp_size;
  assign rsp.evicted     = rsp_evict;

  // Checks
  `FALRU_ASSERT_IMP(a_evict_full, (state == S_UPD) && sel_evict, &valid_vec, "early eviction")
  `FALRU_ASSERT_IMP(a_lru_unique, &valid_vec, $onehot(lru_vec), "full store lacks one LRU entry")
  `FALRU_ASSERT_NXT(a_accept_match, accept, state == S_MATCH, "accepted item not compared next cycle")
  `FALRU_ASSERT_IMP(a_rsp_from_upd, $rose(rsp_valid), $past(upd_go), "response without an update")

endmodule

`default_nettype wire

// ----- sv/falru_cell.sv -----
// ---------------------------------------------------------------------------
// falru_cell
// One entry of the tag store: valid, key, size and recency rank. Takes the
// search results of the lower entries and hands its own on to the next.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module falru_cell
  import falru_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [KEY_W-1:0] cmp_key,
  input  wire upd_cmd_t         cmd,
  input  wire chain_t           chain_in,
  output      chain_t           chain_out,
  output      cell_stat_t       stat
);

  logic              valid;
  logic [RANK_W-1:0] rank;
  logic [KEY_W-1:0]  key;
  logic [SIZE_W-1:0] size;

  logic is_hit;
  logic is_free;
  logic is_lru;
  logic is_target;

  assign is_hit    = valid && (key == cmp_key);
  assign is_free   = !valid;
  assign is_lru    = valid && (rank == LRU_RANK);
  assign is_target = (cmd.idx == cell_idx);

  // Lowest index wins: pass on what came in unless nothing was found yet
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit_f && is_hit) begin
      chain_out.hit_f    = 1'b1;
      chain_out.hit_idx  = cell_idx;
      chain_out.hit_size = size;
      chain_out.hit_rank = rank;
    end
    if (!chain_in.free_f && is_free) begin
      chain_out.free_f   = 1'b1;
      chain_out.free_idx = cell_idx;
    end
    if (!chain_in.lru_f && is_lru) begin
      chain_out.lru_f   = 1'b1;
      chain_out.lru_idx = cell_idx;
    end
  end

  // Valid bit and recency rank
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.apply) begin
      if (is_target) begin
        rank <= '0;
        if (cmd.write) begin
          valid <= 1'b1;
        end
      end else if (valid && (cmd.age_all || (rank < cmd.limit))) begin
        rank <= rank + RANK_W'(1);
      end
    end
  end

  // Payload, written on insert
  always_ff @(posedge clk) begin
    if (cmd.apply && cmd.write && is_target) begin
      key  <= cmd.key;
      size <= cmd.size;
    end
  end

  assign stat.valid = valid;
  assign stat.rank  = rank;

endmodule

`default_nettype wire
